[src/rarst_pkg.sv]
// Shared types and codes of the range-add range-sum block.
// Depends on nothing; imported by the memory, the sequencer, the top level and the testbench.
package rarst_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SUM  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE,
    ST_PMUL,
    ST_PFIN,
    ST_UMUL,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } state_t;

  // One memory word: the difference term and the difference term weighted by its index.
  typedef struct packed {
    logic [31:0] d;
    logic [31:0] dj;
  } word_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic        valid;
    logic [31:0] sum;
  } res_t;

endpackage

[src/rarst_if.sv]
// Handshake channels of the range-add range-sum block.
// Depends on nothing; used by the sequencer and the top level.
interface rarst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         lo;
  logic [10:0]        hi;
  logic signed [31:0] value;
  modport source (output valid, kind, lo, hi, value, input ready);
  modport sink (input valid, kind, lo, hi, value, output ready);
endinterface

interface rarst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum;
  modport source (output valid, sum, input ready);
  modport sink (input valid, sum, output ready);
endinterface

[src/rarst_ram.sv]
// Single-port-write, single-port-read memory with a registered read.
// Depends on rarst_pkg for the word type.
module rarst_ram
  import rarst_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rarst_ctrl.sv]
// Sequencer: clears the memory, walks prefix sums and point updates over it.
// Depends on rarst_pkg and rarst_if; drives the memory ports of rarst_ram.
module rarst_ctrl
  import rarst_pkg::*;
#(
  parameter int LEAVES = 1024,
  parameter int IW     = 10,
  parameter int XW     = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  rarst_in_if.sink      in_ch,
  input  logic          out_free,
  output res_t          res,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output word_t         mem_wdata,
  output logic          mem_re,
  output logic [IW-1:0] mem_raddr,
  input  word_t         mem_rdata
);

  localparam logic [XW-1:0] NX = XW'(LEAVES);

  state_t        state_r, state_nxt;
  kind_t         kind_r, kind_nxt;
  logic [XW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [XW-1:0] idx_r, idx_nxt, j_r, j_nxt;
  logic [31:0]   val_r, val_nxt, w_r, w_nxt, acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic [31:0]   mul_r, mul_nxt, hold_r, hold_nxt, res_r, res_nxt;
  logic          phase_r, phase_nxt, rdv_r, rdv_nxt;
  logic [IW-1:0] clr_r, clr_nxt;

  logic [XW-1:0] lowbit, idx_m1, idx_up, j2, hi_c, lo_x;
  logic [31:0]   pval;
  logic          do_op;
  kind_t         in_kind;

  assign lowbit  = idx_r & (~idx_r + XW'(1));
  assign idx_m1  = idx_r - XW'(1);
  assign idx_up  = idx_r + lowbit;
  assign pval    = mul_r - acc2_r;
  assign in_kind = kind_t'(in_ch.kind);
  assign hi_c    = (32'(in_ch.hi) > 32'(LEAVES)) ? NX : XW'(in_ch.hi);
  assign lo_x    = XW'(in_ch.lo);
  assign j2      = (kind_r == KIND_ADD) ? (hi_r + XW'(1)) : (lo_r + XW'(2));

  always_comb begin
    case (in_kind)
      KIND_LOAD: do_op = 32'(in_ch.lo) < 32'(LEAVES);
      KIND_ADD,
      KIND_SUM:  do_op = 32'(in_ch.lo) < 32'(hi_c);
      default:   do_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    val_r   <= val_nxt;
    w_r     <= w_nxt;
    acc1_r  <= acc1_nxt;
    acc2_r  <= acc2_nxt;
    mul_r   <= mul_nxt;
    hold_r  <= hold_nxt;
    res_r   <= res_nxt;
    phase_r <= phase_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    val_nxt   = val_r;
    w_nxt     = w_r;
    acc1_nxt  = acc1_r;
    acc2_nxt  = acc2_r;
    mul_nxt   = mul_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    phase_nxt = phase_r;
    rdv_nxt   = 1'b0;
    clr_nxt   = clr_r;
    mem_we    = 1'b0;
    mem_waddr = idx_m1[IW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_m1[IW-1:0];
    in_ch.ready = 1'b0;
    res.valid = 1'b0;
    res.sum   = res_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == IW'(LEAVES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = in_kind;
          lo_nxt    = lo_x;
          hi_nxt    = hi_c;
          val_nxt   = in_ch.value;
          phase_nxt = 1'b0;
          acc1_nxt  = '0;
          acc2_nxt  = '0;
          if (!do_op) begin
            res_nxt   = '0;
            state_nxt = (in_kind == KIND_SUM) ? ST_DONE : ST_IDLE;
          end else begin
            case (in_kind)
              KIND_SUM: begin
                idx_nxt   = hi_c;
                pos_nxt   = hi_c;
                state_nxt = ST_PRE;
              end
              KIND_LOAD: begin
                idx_nxt   = lo_x + XW'(1);
                pos_nxt   = lo_x + XW'(1);
                state_nxt = ST_PRE;
              end
              default: begin
                w_nxt     = in_ch.value;
                j_nxt     = lo_x + XW'(1);
                state_nxt = ST_UMUL;
              end
            endcase
          end
        end
      end
      ST_PRE: begin
        // Reads are issued one a cycle; each returned word is summed in the cycle after its read.
        if (idx_r != '0) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r - lowbit;
          rdv_nxt = 1'b1;
        end
        if (rdv_r) begin
          acc1_nxt = acc1_r + mem_rdata.d;
          acc2_nxt = acc2_r + mem_rdata.dj;
        end
        if (idx_r == '0 && !rdv_r) begin
          if (kind_r == KIND_LOAD) begin
            w_nxt     = val_r - acc1_r;
            j_nxt     = lo_r + XW'(1);
            state_nxt = ST_UMUL;
          end else begin
            state_nxt = ST_PMUL;
          end
        end
      end
      ST_PMUL: begin
        mul_nxt   = (32'(pos_r) + 32'd1) * acc1_r;
        state_nxt = ST_PFIN;
      end
      ST_PFIN: begin
        if (!phase_r) begin
          hold_nxt  = pval;
          phase_nxt = 1'b1;
          idx_nxt   = lo_r;
          pos_nxt   = lo_r;
          acc1_nxt  = '0;
          acc2_nxt  = '0;
          state_nxt = ST_PRE;
        end else begin
          res_nxt   = hold_r - pval;
          state_nxt = ST_DONE;
        end
      end
      ST_UMUL: begin
        mul_nxt   = 32'(j_r) * w_r;
        idx_nxt   = j_r;
        state_nxt = ST_UPD_RD;
      end
      ST_UPD_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        mem_we       = 1'b1;
        mem_wdata.d  = mem_rdata.d + w_r;
        mem_wdata.dj = mem_rdata.dj + mul_r;
        idx_nxt      = idx_up;
        if (idx_up <= NX && idx_up != '0) begin
          state_nxt = ST_UPD_RD;
        end else if (!phase_r && j2 <= NX) begin
          // Close the range with the opposite amount one place past its end.
          phase_nxt = 1'b1;
          w_nxt     = '0 - w_r;
          j_nxt     = j2;
          state_nxt = ST_UMUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/range_add_range_sum_tree.sv]
// Range-add range-sum block over LEAVES signed 32-bit elements.
// Input channel in_ch carries one word per item: kind, lo, hi and value.
// Kind load sets element lo to value, kind add adds value to every element
// in [lo, hi), kind sum returns the wrapped sum over [lo, hi) as one word
// on out_ch. Loads, adds and the unused kind give no result word. Positions
// at or past LEAVES are ignored; an empty range sums to zero.
// The elements are held as two difference arrays in one memory of LEAVES
// words; every item is a few prefix walks and point updates over it.
// One item is in work at a time and in_ch.ready is high only when the block
// is idle. A query is two prefix walks, at hi and at lo; the update walks
// of an add or a load read, modify and write back each memory word they
// visit.
// After rst_n is released the memory is cleared one word a cycle, all LEAVES
// words, before the first item is taken.
// A result sits in an output register; if the receiver stalls, the block
// may take and finish further non-query items, and a next query waits for
// the register to drain before its result is written.
module range_add_range_sum_tree
  import rarst_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  rarst_in_if.sink  in_ch,
  rarst_out_if.source out_ch
);

  // Address bits of the memory, and index width wide enough for LEAVES+2.
  localparam int IW = $clog2(LEAVES);
  localparam int XW = IW + 2;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  word_t         mem_wdata, mem_rdata;
  res_t          res;
  logic          out_free;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_sum_r, out_sum_nxt;

  rarst_ram #(
    .DEPTH (LEAVES),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rarst_ctrl #(
    .LEAVES (LEAVES),
    .IW     (IW),
    .XW     (XW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // The output register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = res.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sum   = out_sum_r;

`ifndef SYNTH
  // The sequencer never reads and writes the memory in the same cycle.
  a_no_rw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // A finished result that cannot be stored is offered again.
  a_res_held : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !out_free |=> res.valid && $stable(res.sum))
    else $error("pending result dropped");

  // A stored result appears on the output channel in the next cycle.
  a_res_stored : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && out_free |=> out_valid_r && out_sum_r == $past(res.sum))
    else $error("result not written to the output register");

  // No new item is taken while a result is still being offered.
  a_busy_on_res : assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ch.ready)
    else $error("item accepted while a result is pending");
`endif

endmodule

[test/range_add_range_sum_tree_tb.sv]
// Testbench of the range-add range-sum block: directed and random loads, adds and queries.
// A plain-array model of the elements predicts every query sum; a scoreboard class checks words.
// Depends on rarst_pkg, the rarst_in_if/rarst_out_if interfaces and the block itself.
module range_add_range_sum_tree_tb;
  import rarst_pkg::*;

  localparam int LEAVES = 1024;
  localparam int LIMIT  = 2000000;

  // Scoreboard of pending query sums.
  class sum_board;
    logic [31:0] elem [LEAVES];
    logic [31:0] sums_due [$];
    int errors;

    function new();
      foreach (elem[i]) elem[i] = '0;
      errors = 0;
    endfunction

    // Applies one accepted input word to the element array.
    function void note_item(logic [1:0] kind, logic [9:0] lo, logic [10:0] hi,
                            logic [31:0] value);
      int top;
      logic [31:0] acc;
      top = (hi > LEAVES) ? LEAVES : int'(hi);
      acc = '0;
      case (kind)
        KIND_LOAD: elem[lo] = value;
        KIND_ADD: begin
          for (int i = lo; i < top; i++) elem[i] += value;
        end
        KIND_SUM: begin
          for (int i = lo; i < top; i++) acc += elem[i];
          sums_due.push_back(acc);
        end
        default: ;
      endcase
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (sums_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word sum=%h", got);
        return;
      end
      want = sums_due.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("sum mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rarst_in_if  in_ch ();
  rarst_out_if out_ch ();

  range_add_range_sum_tree #(.LEAVES(LEAVES)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  sum_board board;
  int send_idle;      // percent of cycles the sender sits idle
  int recv_stall;     // percent of cycles the receiver stalls
  int hold_cycles;    // a long receiver hold-off, counted down by the receiver process
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: stalls at random or for a long hold-off, and checks every accepted word.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) board.check_sum(out_ch.sum);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Offers one word and holds it until the block takes it; idle cycles come first.
  task automatic send_word(logic [1:0] kind, logic [9:0] lo, logic [10:0] hi,
                           logic [31:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.lo    <= lo;
    in_ch.hi    <= hi;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(kind, lo, hi, value);
  endtask

  // Random positions, some small, some near the top end and some past it, so both ends of the array get attention.
  function automatic logic [10:0] pick_pos();
    case ($urandom_range(5))
      0: pick_pos = 11'($urandom_range(7));
      1: pick_pos = 11'(LEAVES - $urandom_range(8));
      2: pick_pos = 11'($urandom_range(2047));
      default: pick_pos = 11'($urandom_range(LEAVES));
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] kind;
    logic [10:0] a, b;
    logic [31:0] v;
    int r;
    r = $urandom_range(99);
    kind = (r < 30) ? KIND_LOAD : (r < 60) ? KIND_ADD : (r < 97) ? KIND_SUM : KIND_NONE;
    a = pick_pos();
    b = pick_pos();
    // Most ranges are well formed; the rest keep their raw, possibly empty, order.
    if ($urandom_range(9) < 8 && a > b) begin
      a ^= b; b ^= a; a ^= b;
    end
    v = ($urandom_range(3) == 0) ? 32'($signed($urandom_range(15)) - 8) : $urandom;
    send_word(kind, a[9:0], b, v);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.sums_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    board = new();
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_NONE;
    in_ch.lo    = '0;
    in_ch.hi    = '0;
    in_ch.value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of every field, every kind, empty and overlong ranges.
    send_word(KIND_SUM, 10'd0, 11'd1024, 32'd0);
    send_word(KIND_LOAD, 10'd0, 11'd0, 32'h7fffffff);
    send_word(KIND_LOAD, 10'd1023, 11'd2047, 32'h80000000);
    send_word(KIND_SUM, 10'd0, 11'd1024, 32'd0);
    send_word(KIND_ADD, 10'd0, 11'd1024, 32'hffffffff);
    send_word(KIND_SUM, 10'd0, 11'd2047, 32'hffffffff);
    send_word(KIND_ADD, 10'd5, 11'd5, 32'd99);       // empty range
    send_word(KIND_ADD, 10'd9, 11'd3, 32'd99);       // reversed range
    send_word(KIND_SUM, 10'd9, 11'd3, 32'h12345678);
    send_word(KIND_SUM, 10'd4, 11'd4, 32'd0);
    send_word(KIND_ADD, 10'd1000, 11'd1500, 32'd7); // runs past the end
    send_word(KIND_SUM, 10'd1023, 11'd1024, 32'd0);
    send_word(KIND_NONE, 10'd1, 11'd900, 32'd1234);  // unused kind
    send_word(KIND_SUM, 10'd0, 11'd512, 32'd0);
    send_word(KIND_ADD, 10'd511, 11'd513, 32'h55555555);
    send_word(KIND_LOAD, 10'd512, 11'd0, 32'haaaaaaaa);
    send_word(KIND_SUM, 10'd510, 11'd514, 32'd0);
    send_word(KIND_ADD, 10'd1, 11'd1023, 32'd3);
    send_word(KIND_SUM, 10'd1, 11'd2, 32'd0);
    send_word(KIND_SUM, 10'd1022, 11'd1023, 32'd0);
    wait_drained();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 33) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 33) : 0;
      if (ph == 0) hold_cycles = 3000;  // long hold-off so the block fills and stalls input
      for (int n = 0; n < 210; n++) send_random();
      if (ph == 1) wait_drained();       // sender pauses until all sums are back
    end
    send_idle = 0;
    recv_stall = 0;
    wait_drained();

    if (board.errors == 0 && board.sums_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
